### design/sgi_pkg.sv
package sgi_pkg;

    localparam int COORD_BITS_DEF      = 24;
    localparam int RATIO_FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_BITS        = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SEG_A_X = 3'd0,
        REG_SEG_A_Y = 3'd1,
        REG_SEG_B_X = 3'd2,
        REG_SEG_B_Y = 3'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE       = 2'd0,
        KIND_COLLISION  = 2'd1,
        KIND_PARALLEL   = 2'd2,
        KIND_COINCIDENT = 2'd3
    } kind_t;

    // Per-item flags that travel alongside the divider lanes.
    typedef struct packed {
        logic den_zero;
        logic coin;
        logic neg_a;
        logic neg_b;
        logic sat_a;
        logic sat_b;
    } sgi_flags_t;

endpackage

### design/sgi_if.sv
interface sgi_in_if #(parameter int CB = sgi_pkg::COORD_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sgi_out_if #(parameter int CB = sgi_pkg::COORD_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic signed [CB-1:0] hit_x;
    logic signed [CB-1:0] hit_y;
    modport source (output valid, kind, hit_x, hit_y, input ready);
    modport sink   (input valid, kind, hit_x, hit_y, output ready);
endinterface

interface sgi_cfg_if #(parameter int CB = sgi_pkg::COORD_BITS_DEF);
    logic                              valid;
    logic                              ready;
    logic [sgi_pkg::CFG_IDX_BITS-1:0]  index;
    logic [CB-1:0]                     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/segment_intersection_unit.sv
// Segment intersection unit: tests each query segment (start, end) against a fixed
// segment A-B held in four configuration registers, one result beat per query beat.
// The pipeline takes one query every cycle while the output is not stalled, and its stages are:
// differences, products, cross products, magnitudes, one stage per quotient bit of the two
// restoring dividers, the hit multiply and the final add and clamp. A stall at the output
// freezes the whole pipe.
// Configuration writes are always accepted and must only be made while no query is in
// flight.
module segment_intersection_unit #(
    parameter int COORD_BITS      = sgi_pkg::COORD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = sgi_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sgi_in_if.sink       in_ch,
    sgi_out_if.source    out_ch,
    sgi_cfg_if.sink      cfg
);
    import sgi_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = RATIO_FRAC_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int CW   = PW + 1;
    localparam int DDW  = CW + 2;
    localparam int RW   = DDW + 1;
    localparam int QB   = F + 2;
    localparam int QW   = QB + 1;
    localparam int UW   = QB + 2;
    localparam int HPW  = DW + UW;
    localparam int SW   = HPW - F + 1;
    localparam int ONE  = 1 << F;
    localparam int TOL  = (ONE + 999) / 1000;

    localparam logic signed [UW-1:0] LO_LIM = UW'(-TOL);
    localparam logic signed [UW-1:0] HI_LIM = UW'(ONE + TOL);
    localparam logic signed [SW-1:0] MAXV = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

    // Configuration registers.
    logic signed [C-1:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_x_reg <= '0;
            a_y_reg <= '0;
            b_x_reg <= '0;
            b_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SEG_A_X: a_x_reg <= cfg.data;
                REG_SEG_A_Y: a_y_reg <= cfg.data;
                REG_SEG_B_X: b_x_reg <= cfg.data;
                REG_SEG_B_Y: b_y_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    logic en;
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: coordinate differences.
    logic              v1_reg;
    logic signed [DW-1:0] qdx_reg, qdy_reg, fdx_reg, fdy_reg, ox_reg, oy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qdx_reg <= {in_ch.end_x[C-1], in_ch.end_x} - {in_ch.start_x[C-1], in_ch.start_x};
            qdy_reg <= {in_ch.end_y[C-1], in_ch.end_y} - {in_ch.start_y[C-1], in_ch.start_y};
            fdx_reg <= {b_x_reg[C-1], b_x_reg} - {a_x_reg[C-1], a_x_reg};
            fdy_reg <= {b_y_reg[C-1], b_y_reg} - {a_y_reg[C-1], a_y_reg};
            ox_reg  <= {a_x_reg[C-1], a_x_reg} - {in_ch.start_x[C-1], in_ch.start_x};
            oy_reg  <= {a_y_reg[C-1], a_y_reg} - {in_ch.start_y[C-1], in_ch.start_y};
        end
    end

    // Stage 2: the six partial products.
    logic              v2_reg;
    logic signed [PW-1:0] pd1_reg, pd2_reg, pa1_reg, pa2_reg, pb1_reg, pb2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd1_reg <= qdy_reg * fdx_reg;
            pd2_reg <= qdx_reg * fdy_reg;
            pa1_reg <= qdx_reg * oy_reg;
            pa2_reg <= qdy_reg * ox_reg;
            pb1_reg <= fdx_reg * oy_reg;
            pb2_reg <= fdy_reg * ox_reg;
        end
    end

    // Stage 3: cross products.
    logic              v3_reg;
    logic signed [CW-1:0] den_reg, na_reg, nb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= {pd1_reg[PW-1], pd1_reg} - {pd2_reg[PW-1], pd2_reg};
            na_reg  <= {pa1_reg[PW-1], pa1_reg} - {pa2_reg[PW-1], pa2_reg};
            nb_reg  <= {pb1_reg[PW-1], pb1_reg} - {pb2_reg[PW-1], pb2_reg};
        end
    end

    // Stage 4 and divider lanes. The quotient num * 2^F / den is computed as
    // num * 2^QB / (4 * den), which keeps every partial remainder below the divisor while num < 4 * den.
    logic [CW-1:0] mag_den, mag_na, mag_nb;
    assign mag_den = den_reg[CW-1] ? CW'(-den_reg) : CW'(den_reg);
    assign mag_na  = na_reg[CW-1]  ? CW'(-na_reg)  : CW'(na_reg);
    assign mag_nb  = nb_reg[CW-1]  ? CW'(-nb_reg)  : CW'(nb_reg);

    logic             dv_reg [QB+1];
    logic [DDW-1:0]   dd_reg [QB+1];
    logic [DDW-1:0]   ra_reg [QB+1];
    logic [DDW-1:0]   rb_reg [QB+1];
    logic [QB-1:0]    qa_reg [QB+1];
    logic [QB-1:0]    qb_reg [QB+1];
    sgi_flags_t       fl_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0]          <= {mag_den, 2'b00};
            ra_reg[0]          <= {2'b00, mag_na};
            rb_reg[0]          <= {2'b00, mag_nb};
            qa_reg[0]          <= '0;
            qb_reg[0]          <= '0;
            fl_reg[0].den_zero <= (den_reg == '0);
            fl_reg[0].coin     <= (na_reg == '0) && (nb_reg == '0);
            fl_reg[0].neg_a    <= na_reg[CW-1] ^ den_reg[CW-1];
            fl_reg[0].neg_b    <= nb_reg[CW-1] ^ den_reg[CW-1];
            fl_reg[0].sat_a    <= {2'b00, mag_na} >= {mag_den, 2'b00};
            fl_reg[0].sat_b    <= {2'b00, mag_nb} >= {mag_den, 2'b00};
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [RW-1:0] ra2, rb2;
        logic          ga, gb;

        always_comb
        begin
            ra2 = {ra_reg[k], 1'b0};
            rb2 = {rb_reg[k], 1'b0};
            ga  = ra2 >= {1'b0, dd_reg[k]};
            gb  = rb2 >= {1'b0, dd_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[k+1] <= dd_reg[k];
                ra_reg[k+1] <= ga ? DDW'(ra2 - {1'b0, dd_reg[k]}) : DDW'(ra2);
                rb_reg[k+1] <= gb ? DDW'(rb2 - {1'b0, dd_reg[k]}) : DDW'(rb2);
                qa_reg[k+1] <= {qa_reg[k][QB-2:0], ga};
                qb_reg[k+1] <= {qb_reg[k][QB-2:0], gb};
                fl_reg[k+1] <= fl_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    // Signed ratios, interval test and hit multiply.
    sgi_flags_t fl_end;
    logic [QW-1:0] qa_mag, qb_mag;
    logic signed [UW-1:0] ua, ub;
    logic hit;

    always_comb
    begin
        fl_end = fl_reg[QB];
        qa_mag = fl_end.sat_a ? QW'(1) << QB : {1'b0, qa_reg[QB]};
        qb_mag = fl_end.sat_b ? QW'(1) << QB : {1'b0, qb_reg[QB]};
        ua     = fl_end.neg_a ? -$signed({1'b0, qa_mag}) : $signed({1'b0, qa_mag});
        ub     = fl_end.neg_b ? -$signed({1'b0, qb_mag}) : $signed({1'b0, qb_mag});
        hit    = (ua > LO_LIM) && (ua < HI_LIM) && (ub > LO_LIM) && (ub < HI_LIM);
    end

    logic              vm_reg;
    logic [1:0]        km_reg;
    logic signed [HPW-1:0] px_reg, py_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fl_end.den_zero)
            begin
                km_reg <= fl_end.coin ? KIND_COINCIDENT : KIND_PARALLEL;
            end
            else
            begin
                km_reg <= hit ? KIND_COLLISION : KIND_NONE;
            end
            px_reg <= fdx_reg * ua;
            py_reg <= fdy_reg * ua;
        end
    end

    // Output stage: floor shift, add to A and clamp.
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [C-1:0]  cx, cy;

    always_comb
    begin
        sum_x = SW'(a_x_reg) + SW'(px_reg >>> F);
        sum_y = SW'(a_y_reg) + SW'(py_reg >>> F);
        cx = (sum_x > MAXV) ? C'(MAXV) : (sum_x < MINV) ? C'(MINV) : C'(sum_x);
        cy = (sum_y > MAXV) ? C'(MAXV) : (sum_y < MINV) ? C'(MINV) : C'(sum_y);
    end

    logic              vo_reg;
    logic [1:0]        ko_reg;
    logic signed [C-1:0] hx_reg, hy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ko_reg <= km_reg;
            hx_reg <= (km_reg == KIND_COLLISION) ? cx : '0;
            hy_reg <= (km_reg == KIND_COLLISION) ? cy : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            vm_reg    <= 1'b0;
            vo_reg    <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_ch.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            vm_reg    <= dv_reg[QB];
            vo_reg    <= vm_reg;
        end
    end

    assign out_ch.valid = vo_reg;
    assign out_ch.kind  = ko_reg;
    assign out_ch.hit_x = hx_reg;
    assign out_ch.hit_y = hy_reg;

endmodule

### design/sgi_checker.sv
module sgi_checker #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   kind,
    input logic signed [COORD_BITS-1:0] hit_x,
    input logic signed [COORD_BITS-1:0] hit_y
);
    import sgi_pkg::*;

    // A result that is not a collision carries a zero point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_COLLISION) |-> (hit_x == '0) && (hit_y == '0))
        else $error("non-collision result with non-zero point");

    // A held result stalls the whole pipe, so no query may enter.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("query accepted while the output is stalled");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kind) && $stable(hit_x) && $stable(hit_y))
        else $error("result payload changed while stalled");

endmodule

bind segment_intersection_unit sgi_checker #(.COORD_BITS(COORD_BITS)) u_sgi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .hit_x     (out_ch.hit_x),
    .hit_y     (out_ch.hit_y)
);
